// File: hdl/gdz_pkg.sv
// shared types and constants of the gamepad dead zone filter
package gdz_pkg;

	localparam int SAMP_W = 16;
	localparam int AXIS_DZ_W = 15;
	localparam int CFG_W = 16;
	localparam int ROOT_W = 32;
	localparam int DEN_W = 48;
	localparam int NUM_W = 64;
	localparam int Q_W = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	localparam logic [Q_W-1:0] Q15_MAX = 16'd32767;

	localparam int AXIS_DZ_RST = 250;
	localparam int AXIS_FS_RST = 30000;
	localparam int STICK_DZ_RST = 8000;
	localparam int STICK_FS_RST = 30000;

	typedef enum logic [1:0] {
		REG_AXIS_DZ,
		REG_AXIS_FS,
		REG_STICK_DZ,
		REG_STICK_FS
	} reg_idx_t;

	// control carried through the square root stages
	typedef struct packed {
		logic mode;
		logic neg_x;
		logic neg_y;
		logic dead;
		logic zero_len;
		logic [SAMP_W-1:0] ax;
		logic [SAMP_W-1:0] ay;
	} ctl_t;

	// control carried through the divider stages
	typedef struct packed {
		logic mode;
		logic neg_x;
		logic neg_y;
		logic dead;
		logic zero_len;
		logic sat;
	} dv_tag_t;

endpackage

// File: hdl/gdz_if.sv
// request and result channel interfaces
interface gdz_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic signed [gdz_pkg::SAMP_W-1:0] axis_x;
	logic signed [gdz_pkg::SAMP_W-1:0] axis_y;

	modport source (output valid, req_type, axis_x, axis_y, input ready);
	modport sink (input valid, req_type, axis_x, axis_y, output ready);
endinterface

interface gdz_rsp_if;
	logic valid;
	logic ready;
	logic signed [gdz_pkg::Q_W-1:0] out_x;
	logic signed [gdz_pkg::Q_W-1:0] out_y;
	logic in_dead_zone;

	modport source (output valid, out_x, out_y, in_dead_zone, input ready);
	modport sink (input valid, out_x, out_y, in_dead_zone, output ready);
endinterface

// File: hdl/gamepad_dead_zone_filter.sv
// top level of the gamepad dead zone filter: config registers and the conditioning pipeline
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  req     | in  | valid / ready    | req_type, axis_x, axis_y
//  rsp     | out | valid / ready    | out_x, out_y, in_dead_zone
//  apb     | in  | psel / penable   | paddr, pwdata, prdata (pready tied high)
//
// one request enters per clock while the pipeline advances; the path runs through 3 front stages (magnitude,
// squares, sum and dead zone test), 32 square root stages, 2 scaling stages,
// 16 divider stages and the result register
// the whole pipeline advances together whenever the result register is empty or taken,
// so a stall holds every stage and nothing is lost or repeated
// reset clears the valid bits and loads the register defaults; no clearing pass
module gamepad_dead_zone_filter #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	gdz_req_if.sink req,
	gdz_rsp_if.source rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [gdz_pkg::ADDR_W-1:0] paddr,
	input  logic [gdz_pkg::DATA_W-1:0] pwdata,
	output logic [gdz_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	localparam int SW = gdz_pkg::SAMP_W;
	localparam int CW = gdz_pkg::CFG_W;
	localparam int RW = gdz_pkg::ROOT_W;
	localparam int DW = gdz_pkg::DEN_W;
	localparam int QW = gdz_pkg::Q_W;

	// config registers
	logic [gdz_pkg::AXIS_DZ_W-1:0] axis_dz_q;
	logic [CW-1:0] axis_fs_q;
	logic [CW-1:0] stick_dz_q;
	logic [CW-1:0] stick_fs_q;
	logic [RW-1:0] stick_dz_sq_q;
	logic cfg_wr;
	gdz_pkg::reg_idx_t cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = gdz_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_dz_q <= gdz_pkg::AXIS_DZ_W'(gdz_pkg::AXIS_DZ_RST);
			axis_fs_q <= CW'(gdz_pkg::AXIS_FS_RST);
			stick_dz_q <= CW'(gdz_pkg::STICK_DZ_RST);
			stick_fs_q <= CW'(gdz_pkg::STICK_FS_RST);
			stick_dz_sq_q <= RW'(gdz_pkg::STICK_DZ_RST * gdz_pkg::STICK_DZ_RST);
		end else begin
			// squared stick dead zone is registered and follows the register in the next cycle
			stick_dz_sq_q <= {{(RW-CW){1'b0}}, stick_dz_q} * {{(RW-CW){1'b0}}, stick_dz_q};
			if (cfg_wr) begin
				case (cfg_idx)
					gdz_pkg::REG_AXIS_DZ: axis_dz_q <= pwdata[gdz_pkg::AXIS_DZ_W-1:0];
					gdz_pkg::REG_AXIS_FS: axis_fs_q <= pwdata[CW-1:0];
					gdz_pkg::REG_STICK_DZ: stick_dz_q <= pwdata[CW-1:0];
					gdz_pkg::REG_STICK_FS: stick_fs_q <= pwdata[CW-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			gdz_pkg::REG_AXIS_DZ: prdata = {{(gdz_pkg::DATA_W-gdz_pkg::AXIS_DZ_W){1'b0}}, axis_dz_q};
			gdz_pkg::REG_AXIS_FS: prdata = {{(gdz_pkg::DATA_W-CW){1'b0}}, axis_fs_q};
			gdz_pkg::REG_STICK_DZ: prdata = {{(gdz_pkg::DATA_W-CW){1'b0}}, stick_dz_q};
			gdz_pkg::REG_STICK_FS: prdata = {{(gdz_pkg::DATA_W-CW){1'b0}}, stick_fs_q};
			default: prdata = '0;
		endcase
	end

	// global advance: result register empty or being taken
	logic en;
	logic out_vld_q;
	assign en = !out_vld_q || rsp.ready;
	assign req.ready = en;

	// stage 1: sign-extend the sample and take magnitudes
	logic signed [SAMPLE_BITS-1:0] smp_x;
	logic signed [SAMPLE_BITS-1:0] smp_y;
	logic signed [SW:0] ext_x;
	logic signed [SW:0] ext_y;
	logic vld_s1;
	logic mode_s1;
	logic neg_x_s1;
	logic neg_y_s1;
	logic [SW-1:0] ax_s1;
	logic [SW-1:0] ay_s1;

	assign smp_x = req.axis_x[SAMPLE_BITS-1:0];
	assign smp_y = req.axis_y[SAMPLE_BITS-1:0];
	assign ext_x = (SW+1)'(smp_x);
	assign ext_y = (SW+1)'(smp_y);

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= req.req_type;
			neg_x_s1 <= ext_x[SW];
			neg_y_s1 <= ext_y[SW];
			ax_s1 <= ext_x[SW] ? SW'(-ext_x) : SW'(ext_x);
			ay_s1 <= ext_y[SW] ? SW'(-ext_y) : SW'(ext_y);
		end
	end

	// stage 2: squares and trigger dead zone test
	logic vld_s2;
	logic mode_s2;
	logic neg_x_s2;
	logic neg_y_s2;
	logic trig_dead_s2;
	logic [SW-1:0] ax_s2;
	logic [SW-1:0] ay_s2;
	logic [RW-1:0] sq_x_s2;
	logic [RW-1:0] sq_y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			trig_dead_s2 <= ax_s1 <= {1'b0, axis_dz_q};
			sq_x_s2 <= {{(RW-SW){1'b0}}, ax_s1} * {{(RW-SW){1'b0}}, ax_s1};
			sq_y_s2 <= {{(RW-SW){1'b0}}, ay_s1} * {{(RW-SW){1'b0}}, ay_s1};
		end
	end

	// stage 3: squared length and stick dead zone test
	logic vld_s3;
	logic [RW-1:0] len_sq_s3;
	gdz_pkg::ctl_t ctl_s3;
	logic [RW-1:0] len_sq;

	assign len_sq = sq_x_s2 + sq_y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			len_sq_s3 <= len_sq;
			ctl_s3.mode <= mode_s2;
			ctl_s3.neg_x <= neg_x_s2;
			ctl_s3.neg_y <= neg_y_s2;
			ctl_s3.dead <= mode_s2 ? (len_sq < stick_dz_sq_q) : trig_dead_s2;
			ctl_s3.zero_len <= len_sq == '0;
			ctl_s3.ax <= ax_s2;
			ctl_s3.ay <= ay_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// length in Q.16
	logic sq_vld;
	logic [RW-1:0] sq_root;
	gdz_pkg::ctl_t sq_ctl;

	gdz_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s3),
		.in_rad(len_sq_s3),
		.in_tag(ctl_s3),
		.out_vld(sq_vld),
		.out_root(sq_root),
		.out_tag(sq_ctl)
	);

	// stage 4: scaled length above the dead zone, trigger span
	logic flat;
	logic [CW-1:0] span;
	logic [RW-1:0] dz_sh;
	logic [RW-1:0] span_sh;
	logic [RW-1:0] n_raw;
	logic vld_s4;
	gdz_pkg::ctl_t ctl_s4;
	logic [RW-1:0] lq_s4;
	logic [RW-1:0] n_s4;
	logic [CW-1:0] span_s4;
	logic [CW-1:0] tn_s4;
	logic [CW-1:0] td_s4;
	logic tsat_s4;

	assign flat = stick_fs_q <= stick_dz_q;
	assign span = flat ? CW'(1) : stick_fs_q - stick_dz_q;
	assign dz_sh = {stick_dz_q, 16'b0};
	assign span_sh = {span, 16'b0};
	assign n_raw = sq_root - dz_sh;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4 <= sq_ctl;
			lq_s4 <= sq_root;
			span_s4 <= span;
			// full-scale factor when the stick span is empty or exceeded
			n_s4 <= flat ? span_sh : ((n_raw >= span_sh) ? span_sh : n_raw);
			tsat_s4 <= (axis_fs_q <= {1'b0, axis_dz_q}) || (sq_ctl.ax >= axis_fs_q);
			tn_s4 <= sq_ctl.ax - {1'b0, axis_dz_q};
			td_s4 <= axis_fs_q - {1'b0, axis_dz_q};
		end
	end

	// stage 5: numerators and divisor
	logic [DW-1:0] prod_den;
	logic [DW-1:0] prod_x;
	logic [DW-1:0] prod_y;
	logic vld_s5;
	logic [gdz_pkg::NUM_W-1:0] num_x_s5;
	logic [gdz_pkg::NUM_W-1:0] num_y_s5;
	logic [DW-1:0] den_s5;
	gdz_pkg::dv_tag_t tag_s5;

	assign prod_den = {{(DW-CW){1'b0}}, span_s4} * {{(DW-RW){1'b0}}, lq_s4};
	assign prod_x = {{(DW-SW){1'b0}}, ctl_s4.ax} * {{(DW-RW){1'b0}}, n_s4};
	assign prod_y = {{(DW-SW){1'b0}}, ctl_s4.ay} * {{(DW-RW){1'b0}}, n_s4};

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s4.mode) begin
				num_x_s5 <= {1'b0, prod_x, 15'b0};
				num_y_s5 <= {1'b0, prod_y, 15'b0};
				den_s5 <= prod_den;
			end else begin
				num_x_s5 <= tsat_s4 ? '0 : {33'b0, tn_s4, 15'b0};
				num_y_s5 <= '0;
				den_s5 <= {{(DW-CW){1'b0}}, td_s4};
			end
			tag_s5.mode <= ctl_s4.mode;
			tag_s5.neg_x <= ctl_s4.neg_x;
			tag_s5.neg_y <= ctl_s4.neg_y;
			tag_s5.dead <= ctl_s4.dead;
			tag_s5.zero_len <= ctl_s4.zero_len;
			tag_s5.sat <= !ctl_s4.mode && tsat_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
		end
	end

	logic dv_vld;
	logic [QW-1:0] dv_q_x;
	logic [QW-1:0] dv_q_y;
	gdz_pkg::dv_tag_t dv_tag;

	gdz_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s5),
		.in_num_x(num_x_s5),
		.in_num_y(num_y_s5),
		.in_den(den_s5),
		.in_tag(tag_s5),
		.out_vld(dv_vld),
		.out_q_x(dv_q_x),
		.out_q_y(dv_q_y),
		.out_tag(dv_tag)
	);

	// result register: saturate, restore sign, apply special cases
	logic [QW-1:0] mag_x;
	logic [QW-1:0] mag_y;
	logic blank;
	logic [QW-1:0] out_x_q;
	logic [QW-1:0] out_y_q;
	logic dead_q;

	assign mag_x = (dv_tag.sat || dv_q_x > gdz_pkg::Q15_MAX) ? gdz_pkg::Q15_MAX : dv_q_x;
	assign mag_y = (dv_q_y > gdz_pkg::Q15_MAX) ? gdz_pkg::Q15_MAX : dv_q_y;
	assign blank = dv_tag.dead || (dv_tag.mode && dv_tag.zero_len);

	always_ff @(posedge clk) begin
		if (en) begin
			dead_q <= dv_tag.dead;
			out_x_q <= blank ? '0 : (dv_tag.neg_x ? QW'(0) - mag_x : mag_x);
			out_y_q <= (blank || !dv_tag.mode) ? '0 :
				(dv_tag.neg_y ? QW'(0) - mag_y : mag_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.out_x = out_x_q;
	assign rsp.out_y = out_y_q;
	assign rsp.in_dead_zone = dead_q;

`ifndef ASSERT_OFF
	a_dead_blank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.in_dead_zone |-> rsp.out_x == '0 && rsp.out_y == '0)
		else $error("dead zone result not zero");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.out_x != 16'h8000 && rsp.out_y != 16'h8000)
		else $error("result magnitude beyond q1.15 range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("request stalled with empty result register");

	a_trig_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv_vld && !dv_tag.mode |=> out_y_q == '0)
		else $error("trigger result has nonzero y");
`endif

endmodule

// File: hdl/gdz_sqrt.sv
// pipelined integer square root, one root bit per stage
module gdz_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [gdz_pkg::ROOT_W-1:0] in_rad,
	input  gdz_pkg::ctl_t in_tag,
	output logic out_vld,
	output logic [gdz_pkg::ROOT_W-1:0] out_root,
	output gdz_pkg::ctl_t out_tag
);
	localparam int RW = gdz_pkg::ROOT_W;
	localparam int MW = 2 * RW;

	logic vld_s [0:RW];
	logic [MW-1:0] rem_s [0:RW];
	logic [RW-1:0] root_s [0:RW];
	gdz_pkg::ctl_t tag_s [0:RW];

	// radicand is the input scaled by 2^RW
	assign vld_s[0] = in_vld;
	assign rem_s[0] = {in_rad, {RW{1'b0}}};
	assign root_s[0] = '0;
	assign tag_s[0] = in_tag;

	for (genvar g = 0; g < RW; g++) begin : g_stage
		localparam int B = RW - 1 - g;
		logic [MW:0] trial;
		logic [RW-1:0] bitm;
		logic take;

		// (root + 2^B)^2 - root^2
		assign bitm = {{(RW-1){1'b0}}, 1'b1} << B;
		assign trial = ({{(RW+1){1'b0}}, root_s[g]} << (B + 1))
			+ ({{MW{1'b0}}, 1'b1} << (2 * B));
		assign take = {1'b0, rem_s[g]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= take ? rem_s[g] - trial[MW-1:0] : rem_s[g];
				root_s[g+1] <= take ? (root_s[g] | bitm) : root_s[g];
				tag_s[g+1] <= tag_s[g];
			end
		end
	end

	assign out_vld = vld_s[RW];
	assign out_root = root_s[RW];
	assign out_tag = tag_s[RW];

endmodule

// File: hdl/gdz_div.sv
// pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage
module gdz_div (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [gdz_pkg::NUM_W-1:0] in_num_x,
	input  logic [gdz_pkg::NUM_W-1:0] in_num_y,
	input  logic [gdz_pkg::DEN_W-1:0] in_den,
	input  gdz_pkg::dv_tag_t in_tag,
	output logic out_vld,
	output logic [gdz_pkg::Q_W-1:0] out_q_x,
	output logic [gdz_pkg::Q_W-1:0] out_q_y,
	output gdz_pkg::dv_tag_t out_tag
);
	localparam int QW = gdz_pkg::Q_W;
	localparam int NW = gdz_pkg::NUM_W;
	localparam int DW = gdz_pkg::DEN_W;

	logic vld_s [0:QW];
	logic [NW-1:0] rem_x_s [0:QW];
	logic [NW-1:0] rem_y_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] q_x_s [0:QW];
	logic [QW-1:0] q_y_s [0:QW];
	gdz_pkg::dv_tag_t tag_s [0:QW];

	assign vld_s[0] = in_vld;
	assign rem_x_s[0] = in_num_x;
	assign rem_y_s[0] = in_num_y;
	assign den_s[0] = in_den;
	assign q_x_s[0] = '0;
	assign q_y_s[0] = '0;
	assign tag_s[0] = in_tag;

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int B = QW - 1 - g;
		logic [NW-1:0] trial;
		logic [QW-1:0] bitm;
		logic take_x;
		logic take_y;

		assign trial = {{(NW-DW){1'b0}}, den_s[g]} << B;
		assign bitm = {{(QW-1){1'b0}}, 1'b1} << B;
		assign take_x = rem_x_s[g] >= trial;
		assign take_y = rem_y_s[g] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[g+1] <= take_x ? rem_x_s[g] - trial : rem_x_s[g];
				rem_y_s[g+1] <= take_y ? rem_y_s[g] - trial : rem_y_s[g];
				q_x_s[g+1] <= take_x ? (q_x_s[g] | bitm) : q_x_s[g];
				q_y_s[g+1] <= take_y ? (q_y_s[g] | bitm) : q_y_s[g];
				den_s[g+1] <= den_s[g];
				tag_s[g+1] <= tag_s[g];
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign out_q_x = q_x_s[QW];
	assign out_q_y = q_y_s[QW];
	assign out_tag = tag_s[QW];

endmodule
